FILE: src/otmm_pkg.sv
// ----------------------------------------------------------------------------
// otmm_pkg
// shared constants, types and helpers of the overlapping tile mosaic merge
// ----------------------------------------------------------------------------
package otmm_pkg;

    localparam int MAX_TILES_ACROSS = 4;
    localparam int MAX_TILES_DOWN   = 4;
    localparam int MAX_TILE_WIDTH   = 16;
    localparam int MAX_TILE_HEIGHT  = 16;

    localparam int STORE_DEPTH =
        MAX_TILES_ACROSS * MAX_TILES_DOWN * MAX_TILE_HEIGHT * MAX_TILE_WIDTH;
    localparam int ADDR_W = $clog2(STORE_DEPTH);

    localparam int CAP_ACROSS = (MAX_TILES_ACROSS < 4)  ? MAX_TILES_ACROSS : 4;
    localparam int CAP_DOWN   = (MAX_TILES_DOWN < 4)    ? MAX_TILES_DOWN   : 4;
    localparam int CAP_WIDTH  = (MAX_TILE_WIDTH < 16)   ? MAX_TILE_WIDTH   : 16;
    localparam int CAP_HEIGHT = (MAX_TILE_HEIGHT < 16)  ? MAX_TILE_HEIGHT  : 16;

    localparam int VALUE_W   = 32;
    localparam int ACC_W     = VALUE_W + 2;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TILES_ACROSS = 3'd0,
        CFG_TILES_DOWN   = 3'd1,
        CFG_TILE_WIDTH   = 3'd2,
        CFG_TILE_HEIGHT  = 3'd3
    } t_cfg_idx;

    typedef struct packed {
        logic               kind;
        logic [1:0]         tile_col;
        logic [1:0]         tile_row;
        logic [3:0]         sample_col;
        logic [3:0]         sample_row;
        logic signed [31:0] sample_value;
        logic [5:0]         out_col;
        logic [5:0]         out_row;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] merged_value;
        logic [2:0]         contributors;
        logic               out_of_range;
    } t_out_word;

    // one or two (tile, sample) pairs along one axis
    typedef struct packed {
        logic       two;
        logic [1:0] t0;
        logic [3:0] s0;
        logic [1:0] t1;
        logic [3:0] s1;
    } t_axis;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FETCH,
        ST_LAST,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic decode;
        logic wr_en;
        logic rd_issue;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic dec_load;
        logic dec_oor;
        logic last_rd;
        logic out_full;
    } t_sts;

    function automatic logic [ADDR_W-1:0] store_addr(
        input logic [1:0] tc,
        input logic [1:0] tr,
        input logic [3:0] sc,
        input logic [3:0] sr
    );
        int idx;
        idx = ((int'(tr) * MAX_TILES_ACROSS + int'(tc)) * MAX_TILE_HEIGHT + int'(sr))
              * MAX_TILE_WIDTH + int'(sc);
        return ADDR_W'(idx);
    endfunction

endpackage

FILE: src/overlapping_tile_mosaic_merge_top.sv
// ----------------------------------------------------------------------------
// overlapping_tile_mosaic_merge_top
// merges a mosaic of edge-sharing tiles: loads tile samples into a store and
// returns merged grid samples as the floor mean of 1, 2 or 4 tile samples
//
//   channel  direction  handshake                  word
//   in       input      i_in_valid / o_in_ready    i_in_word  (t_in_word)
//   out      output     o_out_valid / i_out_ready  o_out_word (t_out_word)
//   cfg      input      i_cfg_we                   i_cfg_idx, i_cfg_data
//
// one word at a time: a load is decoded and stored; an out-of-range word is
// handed off; a read makes 1, 2 or 4 fetches on the single store read port
// synchronous active-low reset clears control and config; store is not cleared
// a full output register stalls the sequencer before the result hand-off only
// ----------------------------------------------------------------------------
module overlapping_tile_mosaic_merge_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  otmm_pkg::t_in_word             i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output otmm_pkg::t_out_word            o_out_word,
    input  logic                           i_cfg_we,
    input  logic [otmm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [otmm_pkg::CFG_W-1:0]     i_cfg_data
);
    import otmm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    otmm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    otmm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready high right after an accepted word");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.out_of_range |->
            o_out_word.contributors == 3'd0 && o_out_word.merged_value == 32'sd0)
        else $error("out of range result carries data");

    a_contrib_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.out_of_range |->
            o_out_word.contributors == 3'd1 || o_out_word.contributors == 3'd2
            || o_out_word.contributors == 3'd4)
        else $error("bad contributor count");

    a_one_fetch_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rd_issue |-> !cmd.wr_en && !cmd.out_load && !o_in_ready)
        else $error("store fetch overlaps other work");

endmodule

FILE: src/otmm_ram.sv
// ----------------------------------------------------------------------------
// otmm_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module otmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/otmm_ctrl.sv
// ----------------------------------------------------------------------------
// otmm_ctrl
// sequencer: capture, decode, store fetch, result hand-off
// ----------------------------------------------------------------------------
module otmm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  otmm_pkg::t_sts i_sts,
    output otmm_pkg::t_cmd o_cmd
);
    import otmm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_DECODE;
                end
            end
            ST_DECODE: begin
                o_cmd.decode = 1'b1;
                if (i_sts.dec_oor) begin
                    n_state = ST_DONE;
                end else if (i_sts.dec_load) begin
                    o_cmd.wr_en = 1'b1;
                    n_state     = ST_IDLE;
                end else begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                o_cmd.rd_issue = 1'b1;
                if (i_sts.last_rd) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!i_sts.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/otmm_dp.sv
// ----------------------------------------------------------------------------
// otmm_dp
// datapath: config registers, word register, axis split, tile store,
// accumulator and output register
// ----------------------------------------------------------------------------
module otmm_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [otmm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [otmm_pkg::CFG_W-1:0]          i_cfg_data,
    input  otmm_pkg::t_in_word                  i_in_word,
    input  otmm_pkg::t_cmd                      i_cmd,
    output otmm_pkg::t_sts                      o_sts,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output otmm_pkg::t_out_word                 o_out_word
);
    import otmm_pkg::*;

    function automatic logic [CFG_W-1:0] clamp_cfg(
        input logic [CFG_W-1:0] v,
        input int               lo,
        input int               hi
    );
        logic [CFG_W-1:0] r;
        r = v;
        if (int'(v) < lo) r = CFG_W'(lo);
        if (int'(v) > hi) r = CFG_W'(hi);
        return r;
    endfunction

    function automatic t_axis split_axis(
        input logic [5:0]       pos,
        input logic [CFG_W-1:0] tiles,
        input logic [CFG_W-1:0] span
    );
        logic [6:0] m [4];
        logic [2:0] c;
        logic [6:0] base;
        logic [6:0] x;
        t_axis      a;
        c = '0;
        for (int k = 0; k < 4; k++) begin
            m[k] = 7'(span) * 7'(k + 1);
            if (7'(pos) >= m[k]) c = c + 3'd1;
        end
        base = 7'(span) * 7'(c);
        x    = 7'(pos) - base;
        a    = '0;
        if (x != '0) begin
            a.t0 = c[1:0];
            a.s0 = x[3:0];
        end else if (c == '0) begin
            a.t0 = '0;
            a.s0 = '0;
        end else if (CFG_W'(c) >= tiles) begin
            a.t0 = 2'(tiles - CFG_W'(1));
            a.s0 = span[3:0];
        end else begin
            a.two = 1'b1;
            a.t0  = 2'(c - 3'd1);
            a.s0  = span[3:0];
            a.t1  = c[1:0];
            a.s1  = '0;
        end
        return a;
    endfunction

    logic [2:0]       r_cfg_ta;
    logic [2:0]       r_cfg_td;
    logic [CFG_W-1:0] r_cfg_tw;
    logic [CFG_W-1:0] r_cfg_th;

    t_in_word  r_item;
    logic      r_oor;
    t_axis     r_xa;
    t_axis     r_ya;
    logic [1:0] r_idx;
    logic      r_pend;
    logic signed [ACC_W-1:0] r_acc;
    logic      r_out_valid;
    t_out_word r_out_word;

    logic [CFG_W-1:0] ta;
    logic [CFG_W-1:0] td;
    logic [CFG_W-1:0] tw;
    logic [CFG_W-1:0] th;
    logic [CFG_W-1:0] span_x;
    logic [CFG_W-1:0] span_y;
    logic [6:0]       nx;
    logic [6:0]       ny;
    logic             load_oor;
    logic             read_oor;
    t_axis            xa;
    t_axis            ya;

    logic [1:0]        shift;
    logic [1:0]        last_idx;
    logic              sel_i;
    logic              sel_j;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [VALUE_W-1:0] ram_rdata;
    logic signed [ACC_W-1:0] rd_ext;
    logic signed [ACC_W-1:0] mean;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ta <= 3'd1;
            r_cfg_td <= 3'd1;
            r_cfg_tw <= CFG_W'(16);
            r_cfg_th <= CFG_W'(16);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TILES_ACROSS: r_cfg_ta <= i_cfg_data[2:0];
                CFG_TILES_DOWN:   r_cfg_td <= i_cfg_data[2:0];
                CFG_TILE_WIDTH:   r_cfg_tw <= i_cfg_data;
                CFG_TILE_HEIGHT:  r_cfg_th <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign ta     = clamp_cfg(CFG_W'(r_cfg_ta), 1, CAP_ACROSS);
    assign td     = clamp_cfg(CFG_W'(r_cfg_td), 1, CAP_DOWN);
    assign tw     = clamp_cfg(r_cfg_tw, 2, CAP_WIDTH);
    assign th     = clamp_cfg(r_cfg_th, 2, CAP_HEIGHT);
    assign span_x = tw - CFG_W'(1);
    assign span_y = th - CFG_W'(1);
    assign nx     = 7'(ta) * 7'(span_x) + 7'd1;
    assign ny     = 7'(td) * 7'(span_y) + 7'd1;

    assign load_oor = (CFG_W'(r_item.tile_col) >= ta) || (CFG_W'(r_item.tile_row) >= td)
                   || (CFG_W'(r_item.sample_col) >= tw) || (CFG_W'(r_item.sample_row) >= th);
    assign read_oor = (7'(r_item.out_col) >= nx) || (7'(r_item.out_row) >= ny);

    assign xa = split_axis(r_item.out_col, ta, span_x);
    assign ya = split_axis(r_item.out_row, td, span_y);

    // word and decode registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_word;
        end
        if (i_cmd.decode) begin
            r_oor <= (r_item.kind == KIND_READ) ? read_oor : load_oor;
            r_xa  <= xa;
            r_ya  <= ya;
        end
    end

    // fetch order: x inner, y outer
    assign shift    = 2'(r_xa.two) + 2'(r_ya.two);
    assign last_idx = 2'((3'd1 << shift) - 3'd1);
    assign sel_i    = r_xa.two ? r_idx[0] : 1'b0;
    assign sel_j    = r_xa.two ? r_idx[1] : r_idx[0];
    assign rd_addr  = store_addr(sel_i ? r_xa.t1 : r_xa.t0, sel_j ? r_ya.t1 : r_ya.t0,
                                 sel_i ? r_xa.s1 : r_xa.s0, sel_j ? r_ya.s1 : r_ya.s0);
    assign wr_addr  = store_addr(r_item.tile_col, r_item.tile_row,
                                 r_item.sample_col, r_item.sample_row);

    otmm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (wr_addr),
        .i_wdata (r_item.sample_value),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    assign rd_ext = ACC_W'(signed'(ram_rdata));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_pend <= 1'b0;
        end else begin
            r_pend <= i_cmd.rd_issue;
            if (i_cmd.decode) begin
                r_idx <= '0;
            end else if (i_cmd.rd_issue) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decode) begin
            r_acc <= '0;
        end else if (r_pend) begin
            r_acc <= r_acc + rd_ext;
        end
    end

    assign mean = r_acc >>> shift;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_oor) begin
                r_out_word.merged_value <= '0;
                r_out_word.contributors <= '0;
                r_out_word.out_of_range <= 1'b1;
            end else begin
                r_out_word.merged_value <= mean[VALUE_W-1:0];
                r_out_word.contributors <= 3'd1 << shift;
                r_out_word.out_of_range <= 1'b0;
            end
        end
    end

    assign o_sts.dec_load = (r_item.kind == KIND_LOAD);
    assign o_sts.dec_oor  = (r_item.kind == KIND_READ) ? read_oor : load_oor;
    assign o_sts.last_rd  = (r_idx == last_idx);
    assign o_sts.out_full = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

FILE: sim/otmm_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// otmm_checker
// watches the load/read, result and register channels of the mosaic merge,
// keeps its own tile store and size registers, predicts each result word
// and compares it field by field with what the block hands out
// ----------------------------------------------------------------------------
module otmm_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  otmm_pkg::t_in_word             i_in_word,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  otmm_pkg::t_out_word            i_out_word,
    input  logic                           i_cfg_we,
    input  logic [otmm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [otmm_pkg::CFG_W-1:0]     i_cfg_data,
    output int                             o_pending,
    output int                             o_fail_count
);
    import otmm_pkg::*;

    localparam int EXP_DEPTH = 64;

    logic [2:0]         reg_across;
    logic [2:0]         reg_down;
    logic [4:0]         reg_width;
    logic [4:0]         reg_height;
    logic [VALUE_W-1:0] mirror [STORE_DEPTH];
    t_out_word          exp_ring [EXP_DEPTH];
    int                 exp_head = 0;
    int                 exp_tail = 0;
    int                 waiting = 0;
    int                 misses = 0;

    assign o_pending    = waiting;
    assign o_fail_count = misses;

    function automatic int clamp_reg(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int slot(input int tc, input int tr, input int sc, input int sr);
        return ((tr * MAX_TILES_ACROSS + tc) * MAX_TILE_HEIGHT + sr) * MAX_TILE_WIDTH + sc;
    endfunction

    // one merged coordinate -> one or two (tile, sample) pairs
    function automatic int split_pos(input int pos, input int tiles, input int size,
                                     output int t0, output int s0,
                                     output int t1, output int s1);
        int span;
        span = size - 1;
        t0 = pos / span;
        s0 = pos % span;
        t1 = 0;
        s1 = 0;
        if (s0 != 0 || t0 == 0) return 1;
        if (t0 >= tiles) begin
            t0 = tiles - 1;
            s0 = span;
            return 1;
        end
        t1 = t0;
        t0 = t0 - 1;
        s0 = span;
        return 2;
    endfunction

    task automatic add_expected(input t_out_word res);
        if (exp_tail - exp_head >= EXP_DEPTH) begin
            $display("%0t: expected word queue overflow", $time);
            misses++;
        end else begin
            exp_ring[exp_tail % EXP_DEPTH] = res;
            exp_tail++;
        end
    endtask

    task automatic absorb_word(input t_in_word w);
        int                 ta, td, tw, th, nx, ny, nxc, nyc, cnt;
        int                 xt[2], xs[2], yt[2], ys[2];
        logic [VALUE_W-1:0] v;
        logic signed [33:0] sum;
        logic signed [33:0] mean;
        t_out_word          res;
        ta  = clamp_reg(int'(reg_across), 1, CAP_ACROSS);
        td  = clamp_reg(int'(reg_down), 1, CAP_DOWN);
        tw  = clamp_reg(int'(reg_width), 2, CAP_WIDTH);
        th  = clamp_reg(int'(reg_height), 2, CAP_HEIGHT);
        res = '0;
        if (w.kind == KIND_LOAD) begin
            if (int'(w.tile_col) >= ta || int'(w.tile_row) >= td ||
                int'(w.sample_col) >= tw || int'(w.sample_row) >= th) begin
                res.out_of_range = 1'b1;
                add_expected(res);
            end else begin
                mirror[slot(w.tile_col, w.tile_row, w.sample_col, w.sample_row)] =
                    w.sample_value;
            end
        end else begin
            nx = ta * (tw - 1) + 1;
            ny = td * (th - 1) + 1;
            if (int'(w.out_col) >= nx || int'(w.out_row) >= ny) begin
                res.out_of_range = 1'b1;
            end else begin
                nxc = split_pos(w.out_col, ta, tw, xt[0], xs[0], xt[1], xs[1]);
                nyc = split_pos(w.out_row, td, th, yt[0], ys[0], yt[1], ys[1]);
                sum = '0;
                for (int j = 0; j < nyc; j++) begin
                    for (int i = 0; i < nxc; i++) begin
                        v   = mirror[slot(xt[i], yt[j], xs[i], ys[j])];
                        sum = sum + {{2{v[VALUE_W-1]}}, v};
                    end
                end
                cnt  = nxc * nyc;
                mean = sum >>> ((cnt == 4) ? 2 : (cnt == 2) ? 1 : 0);
                res.merged_value = mean[VALUE_W-1:0];
                res.contributors = 3'(cnt);
            end
            add_expected(res);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            reg_across = 3'd1;
            reg_down   = 3'd1;
            reg_width  = 5'd16;
            reg_height = 5'd16;
            exp_head   = 0;
            exp_tail   = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TILES_ACROSS: reg_across = i_cfg_data[2:0];
                    CFG_TILES_DOWN:   reg_down   = i_cfg_data[2:0];
                    CFG_TILE_WIDTH:   reg_width  = i_cfg_data;
                    CFG_TILE_HEIGHT:  reg_height = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (exp_tail == exp_head) begin
                    $display("%0t: expected none, got value %0d count %0d oor %0b",
                             $time, i_out_word.merged_value, i_out_word.contributors,
                             i_out_word.out_of_range);
                    misses++;
                end else begin
                    want = exp_ring[exp_head % EXP_DEPTH];
                    exp_head++;
                    if (i_out_word.merged_value !== want.merged_value ||
                        i_out_word.contributors !== want.contributors ||
                        i_out_word.out_of_range !== want.out_of_range) begin
                        $display("%0t: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                                 $time, want.merged_value, want.contributors,
                                 want.out_of_range, i_out_word.merged_value,
                                 i_out_word.contributors, i_out_word.out_of_range);
                        misses++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) absorb_word(i_in_word);
        end
        waiting = exp_tail - exp_head;
    end

endmodule

FILE: sim/tb_overlapping_tile_mosaic_merge_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_overlapping_tile_mosaic_merge_top
// drives tile loads and merged reads into the mosaic merge under bursty input
// and a stalling output, steps through mosaic sizes (largest, smallest, mixed, random
// and out-of-range register values), and reports the checker's verdict
// ----------------------------------------------------------------------------
module tb_overlapping_tile_mosaic_merge_top;
    import otmm_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int POS_MAX      = 63;
    localparam int PHASE_WORDS  = 220;
    localparam int NUM_PHASES   = 8;
    localparam int HOLD_PHASE   = 2;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE       = 10;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    t_in_word             in_word;
    logic                 out_valid;
    logic                 out_ready;
    t_out_word            out_word;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;
    int                   pending;
    int                   fail_count;

    int eff_across = 1;
    int eff_down   = 1;
    int eff_width  = 16;
    int eff_height = 16;
    int burst_left = 0;
    int words_sent = 0;
    int phase_num  = -1;
    bit loaded [STORE_DEPTH];

    always #(CLK_PERIOD / 2) clk = ~clk;

    overlapping_tile_mosaic_merge_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    otmm_checker u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_word   (out_word),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    function automatic int clampi(input int v, input int lo, input int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return -32'($urandom_range(1, 4));
            3: return 32'($urandom_range(0, 4));
            default: return $urandom();
        endcase
    endfunction

    task automatic send_word(input t_in_word w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        burst_left--;
        words_sent++;
    endtask

    // stop offering, wait for every outstanding result, let a load finish
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cfg_put(input t_cfg_idx idx, input int data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_W'(data);
        @(posedge clk);
    endtask

    task automatic apply_sizes(input int a, input int d, input int w, input int h,
                               input bit junk);
        cfg_put(CFG_TILES_ACROSS, a);
        cfg_put(CFG_TILES_DOWN, d);
        cfg_put(CFG_TILE_WIDTH, w);
        cfg_put(CFG_TILE_HEIGHT, h);
        if (junk) begin
            cfg_put(t_cfg_idx'($urandom_range(int'(CFG_TILE_HEIGHT) + 1,
                                              (1 << CFG_IDX_W) - 1)),
                    $urandom_range(0, (1 << CFG_W) - 1));
        end
        cfg_we <= 1'b0;
        eff_across = clampi(int'(3'(a)), 1, CAP_ACROSS);
        eff_down   = clampi(int'(3'(d)), 1, CAP_DOWN);
        eff_width  = clampi(int'(5'(w)), 2, CAP_WIDTH);
        eff_height = clampi(int'(5'(h)), 2, CAP_HEIGHT);
    endtask

    task automatic put_load(input int tc, input int tr, input int sc, input int sr,
                            input logic [VALUE_W-1:0] val);
        t_in_word w;
        w.kind         = KIND_LOAD;
        w.tile_col     = 2'(tc);
        w.tile_row     = 2'(tr);
        w.sample_col   = 4'(sc);
        w.sample_row   = 4'(sr);
        w.sample_value = val;
        w.out_col      = 6'($urandom);
        w.out_row      = 6'($urandom);
        if (tc < eff_across && tr < eff_down && sc < eff_width && sr < eff_height)
            loaded[store_addr(w.tile_col, w.tile_row, w.sample_col, w.sample_row)] = 1'b1;
        send_word(w);
    endtask

    task automatic put_read(input int oc, input int orow);
        t_in_word w;
        w.kind         = KIND_READ;
        w.tile_col     = 2'($urandom);
        w.tile_row     = 2'($urandom);
        w.sample_col   = 4'($urandom);
        w.sample_row   = 4'($urandom);
        w.sample_value = $urandom();
        w.out_col      = 6'(oc);
        w.out_row      = 6'(orow);
        send_word(w);
    endtask

    task automatic axis_pairs(input int pos, input int tiles, input int size,
                              output int n, output int t0, output int s0,
                              output int t1, output int s1);
        int span;
        span = size - 1;
        n  = 1;
        t0 = pos / span;
        s0 = pos % span;
        t1 = 0;
        s1 = 0;
        if (s0 == 0 && t0 != 0) begin
            if (t0 >= tiles) begin
                t0 = tiles - 1;
                s0 = span;
            end else begin
                t1 = t0;
                t0 = t0 - 1;
                s0 = span;
                n  = 2;
            end
        end
    endtask

    // every tile sample under the spot gets loaded before the read
    task automatic fill_and_read(input int oc, input int orow);
        int nxc, nyc;
        int xt[2], xs[2], yt[2], ys[2];
        axis_pairs(oc, eff_across, eff_width, nxc, xt[0], xs[0], xt[1], xs[1]);
        axis_pairs(orow, eff_down, eff_height, nyc, yt[0], ys[0], yt[1], ys[1]);
        for (int j = 0; j < nyc; j++) begin
            for (int i = 0; i < nxc; i++) begin
                if (!loaded[store_addr(2'(xt[i]), 2'(yt[j]), 4'(xs[i]), 4'(ys[j]))])
                    put_load(xt[i], yt[j], xs[i], ys[j], pick_value());
            end
        end
        put_read(oc, orow);
    endtask

    task automatic random_item();
        int pick, nx, ny, oc, orow;
        nx   = eff_across * (eff_width - 1) + 1;
        ny   = eff_down * (eff_height - 1) + 1;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            // lean on the shared edge lines
            oc   = ($urandom_range(0, 4) < 2) ?
                   (eff_width - 1) * $urandom_range(0, eff_across) : $urandom_range(0, nx - 1);
            orow = ($urandom_range(0, 4) < 2) ?
                   (eff_height - 1) * $urandom_range(0, eff_down) : $urandom_range(0, ny - 1);
            fill_and_read(oc, orow);
        end else if (pick < 65) begin
            oc   = $urandom_range(0, POS_MAX);
            orow = $urandom_range(0, POS_MAX);
            if (oc < nx && orow < ny) begin
                if ($urandom_range(0, 1)) oc = $urandom_range(nx, POS_MAX);
                else orow = $urandom_range(ny, POS_MAX);
            end
            put_read(oc, orow);
        end else if (pick < 90) begin
            put_load($urandom_range(0, eff_across - 1), $urandom_range(0, eff_down - 1),
                     $urandom_range(0, eff_width - 1), $urandom_range(0, eff_height - 1),
                     pick_value());
        end else begin
            put_load($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 15),
                     $urandom_range(0, 15), pick_value());
        end
        if ($urandom_range(0, 199) == 0) drain();
    endtask

    initial begin : receiver
        int seg, mode;
        bit held;
        held      = 1'b0;
        out_ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (!held && phase_num == HOLD_PHASE) begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else begin
                seg  = $urandom_range(1, 48);
                mode = $urandom_range(0, 3);
                repeat (seg) begin
                    case (mode)
                        0: out_ready <= 1'b1;
                        1: out_ready <= 1'($urandom_range(0, 1));
                        2: out_ready <= ($urandom_range(0, 3) == 0);
                        default: out_ready <= ($urandom_range(0, 3) != 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    initial begin : stimulus
        int start, a, d, w, h;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_word  = '0;
        cfg_we   = 1'b0;
        cfg_idx  = '0;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single 16x16 tile from reset
        put_load(0, 0, 15, 15, 32'h7fff_ffff);
        put_read(15, 15);
        put_read(16, 3);
        put_load(1, 0, 0, 0, 32'h1234_5678);
        put_load(0, 0, 0, 0, 32'h8000_0000);
        put_read(0, 0);
        drain();

        // 2x2 tiles of 3x3 samples, 5x5 grid
        apply_sizes(2, 2, 3, 3, 1'b1);
        put_load(0, 0, 2, 2, 32'h8000_0000);
        put_load(1, 0, 0, 2, 32'h8000_0000);
        put_load(0, 1, 2, 0, 32'h8000_0000);
        put_load(1, 1, 0, 0, 32'h8000_0001);
        put_read(2, 2);
        put_load(0, 0, 2, 1, 32'hffff_ffff);
        put_load(1, 0, 0, 1, 32'h0000_0000);
        put_read(2, 1);
        put_load(0, 0, 1, 1, 32'h7fff_ffff);
        put_read(1, 1);
        fill_and_read(1, 2);
        put_load(1, 1, 2, 2, 32'h0000_0003);
        put_read(4, 4);
        put_read(5, 0);
        put_read(POS_MAX, POS_MAX);
        put_load(0, 0, 3, 0, 32'h0000_0001);
        put_load(0, 2, 0, 0, 32'h0000_0001);

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            case (p)
                0: begin a = 4; d = 4; w = 16; h = 16; end
                1: begin a = 1; d = 1; w = 2;  h = 2;  end
                2: begin a = 4; d = 1; w = 2;  h = 16; end
                3: begin a = 1; d = 4; w = 16; h = 2;  end
                4: begin a = 0; d = 31; w = 1; h = 31; end
                default: begin
                    a = $urandom_range(0, 31);
                    d = $urandom_range(0, 31);
                    w = $urandom_range(0, 31);
                    h = $urandom_range(0, 31);
                end
            endcase
            apply_sizes(a, d, w, h, p == 4 || $urandom_range(0, 2) == 0);
            phase_num = p;
            start = words_sent;
            while (words_sent - start < PHASE_WORDS) random_item();
        end

        drain();
        if (fail_count == 0) begin
            $display("overlapping_tile_mosaic_merge_top: match");
        end else begin
            $display("overlapping_tile_mosaic_merge_top: mismatch");
        end
        $finish;
    end

    initial begin : watchdog
        #(64'd20_000_000);
        $display("overlapping_tile_mosaic_merge_top: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
src/otmm_pkg.sv
src/otmm_ram.sv
src/otmm_ctrl.sv
src/otmm_dp.sv
src/overlapping_tile_mosaic_merge_top.sv
sim/otmm_checker.sv
sim/tb_overlapping_tile_mosaic_merge_top.sv
